// File: hw/rtl/hcd_pkg.sv
// Shared types, constants and character helpers for the chunked body decoder.
package hcd_pkg;

  localparam int SIZE_BITS_DEFAULT = 32;

  localparam logic [2:0] PH_WS      = 3'd0;
  localparam logic [2:0] PH_DIGITS  = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_TRAILCR = 3'd4;
  localparam logic [2:0] PH_TRAILLF = 3'd5;
  localparam logic [2:0] PH_STOP    = 3'd6;

  localparam logic [1:0] CAUSE_ZERO_SIZE = 2'd0;
  localparam logic [1:0] CAUSE_EXHAUSTED = 2'd1;
  localparam logic [1:0] CAUSE_NO_DIGIT  = 2'd2;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       body_end;
    logic [1:0] end_cause;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

// File: hw/rtl/hcd_step.sv
// Per-item parse step: next phase, next count and the result for one byte.
module hcd_step #(
  parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEFAULT
) (
  input  hcd_pkg::in_item_t      item,
  input  logic [2:0]             phase,
  input  logic [SIZE_BITS-1:0]   count,
  output logic [2:0]             phase_nxt,
  output logic [SIZE_BITS-1:0]   count_nxt,
  output logic                   res_valid,
  output hcd_pkg::out_item_t     res
);

  always_comb begin
    logic [2:0]           ph;
    logic [SIZE_BITS-1:0] cnt;
    logic                 consumed;
    logic                 ws_in_size;
    logic                 has;
    logic                 ended;
    logic                 line_done;
    logic [1:0]           cause;
    hcd_pkg::hex_digit_t  hd;

    ph         = phase;
    cnt        = count;
    consumed   = 1'b0;
    ws_in_size = 1'b0;
    has        = 1'b0;
    ended      = 1'b0;
    line_done  = 1'b0;
    cause      = hcd_pkg::CAUSE_ZERO_SIZE;
    hd         = hcd_pkg::hex_decode(item.body_byte);

    if (ph == hcd_pkg::PH_TRAILCR) begin
      ph = hcd_pkg::PH_TRAILLF;
      if (item.body_byte == hcd_pkg::CHAR_CR) consumed = 1'b1;
    end
    if (!consumed && ph == hcd_pkg::PH_TRAILLF) begin
      ph = hcd_pkg::PH_WS;
      if (item.body_byte == hcd_pkg::CHAR_LF) consumed = 1'b1;
    end

    if (!consumed) begin
      unique case (ph)
        hcd_pkg::PH_WS: begin
          if (hd.ok) begin
            cnt = {{(SIZE_BITS-4){1'b0}}, hd.val};
            ph  = hcd_pkg::PH_DIGITS;
          end else if (hcd_pkg::is_space(item.body_byte)) begin
            ws_in_size = 1'b1;
          end else begin
            ended = 1'b1;
            cause = hcd_pkg::CAUSE_NO_DIGIT;
          end
        end
        hcd_pkg::PH_DIGITS: begin
          if (hd.ok) begin
            if (|cnt[SIZE_BITS-1:SIZE_BITS-4]) begin
              cnt = '1;
            end else begin
              cnt = {cnt[SIZE_BITS-5:0], hd.val};
            end
          end else if (item.body_byte == hcd_pkg::CHAR_LF) begin
            line_done = 1'b1;
          end else begin
            ph = hcd_pkg::PH_EXT;
          end
        end
        hcd_pkg::PH_EXT: begin
          if (item.body_byte == hcd_pkg::CHAR_LF) line_done = 1'b1;
        end
        hcd_pkg::PH_DATA: begin
          has = 1'b1;
          cnt = cnt - SIZE_BITS'(1);
          if (cnt == '0) ph = hcd_pkg::PH_TRAILCR;
        end
        default: begin
          ph = hcd_pkg::PH_STOP;
        end
      endcase
    end

    if (line_done) begin
      if (cnt == '0) begin
        ended = 1'b1;
        cause = hcd_pkg::CAUSE_ZERO_SIZE;
      end else begin
        ph = hcd_pkg::PH_DATA;
      end
    end

    if (item.body_last && !ended && ph != hcd_pkg::PH_STOP) begin
      ended = 1'b1;
      if (ph == hcd_pkg::PH_WS) begin
        cause = ws_in_size ? hcd_pkg::CAUSE_NO_DIGIT : hcd_pkg::CAUSE_EXHAUSTED;
      end else if ((ph == hcd_pkg::PH_DIGITS || ph == hcd_pkg::PH_EXT) && cnt == '0) begin
        cause = hcd_pkg::CAUSE_ZERO_SIZE;
      end else begin
        cause = hcd_pkg::CAUSE_EXHAUSTED;
      end
    end

    if (item.body_last) begin
      ph  = hcd_pkg::PH_WS;
      cnt = '0;
    end else if (ended) begin
      ph  = hcd_pkg::PH_STOP;
      cnt = '0;
    end

    phase_nxt        = ph;
    count_nxt        = cnt;
    res_valid        = has || ended;
    res.payload_byte = has ? item.body_byte : 8'd0;
    res.has_byte     = has;
    res.body_end     = ended;
    res.end_cause    = ended ? cause : hcd_pkg::CAUSE_ZERO_SIZE;
  end

endmodule

// File: hw/rtl/http_chunked_body_decoder.sv
// An accepted item is parsed from the input register and its result registered onto out_data.
// One item per cycle unless out_stall holds a result: one parse step, two registers.
// Items that produce no result are absorbed without any output handshake.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// whitespace skipping before a chunk size, with the count cleared.
// Top level of the chunked body decoder: input register, parse state and result register.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hcd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hcd_pkg::out_item_t out_data
);

  logic                 in_valid_r;
  hcd_pkg::in_item_t    in_data_r;
  logic [2:0]           phase_r;
  logic [SIZE_BITS-1:0] count_r;
  logic                 out_valid_r;
  hcd_pkg::out_item_t   out_data_r;

  logic [2:0]           phase_nxt;
  logic [SIZE_BITS-1:0] count_nxt;
  logic                 res_valid;
  hcd_pkg::out_item_t   res;
  logic                 out_free;
  logic                 fire;

  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hcd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .item      (in_data_r),
    .phase     (phase_r),
    .count     (count_r),
    .phase_nxt (phase_nxt),
    .count_nxt (count_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcd_pkg::PH_WS;
      count_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule
